// File: rtl/core/sltd_pkg.sv
`timescale 1ns / 1ps

package sltd_pkg;

    localparam int DEFAULT_SLOTS = 64;

    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int POS_W    = 6;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 7;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_ADD    = 3'd0;
    localparam t_kind KIND_ADD_AT = 3'd1;
    localparam t_kind KIND_REMOVE = 3'd2;
    localparam t_kind KIND_READ   = 3'd3;
    localparam t_kind KIND_CLEAR  = 3'd4;

    localparam t_status STAT_OK       = 3'd0;
    localparam t_status STAT_FULL     = 3'd1;
    localparam t_status STAT_OCCUPIED = 3'd2;
    localparam t_status STAT_EMPTY    = 3'd3;
    localparam t_status STAT_RANGE    = 3'd4;

endpackage

// File: rtl/core/slot_table_with_dense_list.sv
`timescale 1ns / 1ps

// Slot table with a dense list of occupied slots, one request word in and one result word
// out per request. Each slot keeps an occupancy bit and a 16-bit handle in a slot memory,
// and the occupied slot numbers are kept in a dense-list memory, a remove moving the last
// entry into the freed place; both have one write and one registered read port, and all
// searches walk them one entry per cycle. An add walks the slot memory up to the highest
// index, a remove walks it down from the highest index and then searches the dense list,
// and a clear sweeps the whole slot memory. After reset the slot memory is swept clear
// with the input ready low. A new request word is taken as soon as the previous one has
// reached the output register, even while that result still waits to be taken.
module slot_table_with_dense_list
    import sltd_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [POS_W-1:0]    i_position,
    input  logic [HANDLE_W-1:0] i_handle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [LIVE_W-1:0]   o_live_count,
    output logic [SLOT_W-1:0]   o_top_slot
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SWEEP     = 4'd1;
    localparam logic [3:0] S_ADD_SCAN  = 4'd2;
    localparam logic [3:0] S_AT_CHK    = 4'd3;
    localparam logic [3:0] S_RM_CHK    = 4'd4;
    localparam logic [3:0] S_SHRINK    = 4'd5;
    localparam logic [3:0] S_DSCAN     = 4'd6;
    localparam logic [3:0] S_DMOVE_RD  = 4'd7;
    localparam logic [3:0] S_DMOVE_WR  = 4'd8;
    localparam logic [3:0] S_RD_SLOT   = 4'd9;
    localparam logic [3:0] S_RD_HANDLE = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    logic [HANDLE_W:0] r_slot_mem [SLOTS];
    logic [AW-1:0]     r_dense_mem [SLOTS];

    logic [3:0]          r_state, n_state;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_pidx;
    logic                r_pvalid, n_pvalid;
    logic [AW-1:0]       r_top, n_top;
    logic [CW-1:0]       r_count, n_count;
    logic                r_emit, n_emit;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    t_status             r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [LIVE_W-1:0]   r_out_live, n_out_live;
    logic [SLOT_W-1:0]   r_out_top, n_out_top;
    logic [HANDLE_W:0]   r_sdata;
    logic [AW-1:0]       r_ddata;

    logic [AW-1:0]     s_raddr, s_waddr, d_raddr, d_waddr, d_wdata, claim_slot, last_pos;
    logic [HANDLE_W:0] s_wdata;
    logic              s_we, d_we, claim_en, occ;

    assign occ      = r_sdata[HANDLE_W];
    assign last_pos = AW'(r_count - CW'(1));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pvalid     = 1'b1;
        n_top        = r_top;
        n_count      = r_count;
        n_emit       = r_emit;
        n_slot       = r_slot;
        n_handle     = r_handle;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_handle = r_res_handle;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_handle = r_out_handle;
        n_out_live   = r_out_live;
        n_out_top    = r_out_top;
        s_raddr      = r_idx;
        d_raddr      = r_idx;
        s_we         = 1'b0;
        s_waddr      = r_idx;
        s_wdata      = '0;
        d_we         = 1'b0;
        d_waddr      = r_idx;
        d_wdata      = r_idx;
        claim_en     = 1'b0;
        claim_slot   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                s_raddr  = AW'(i_slot);
                d_raddr  = AW'(i_position);
                n_pvalid = 1'b0;
                if (i_in_valid) begin
                    n_slot       = i_slot;
                    n_handle     = i_handle;
                    n_res_status = STAT_OK;
                    n_res_slot   = '0;
                    n_res_handle = '0;
                    n_idx        = '0;
                    unique case (i_kind)
                        KIND_ADD: begin
                            n_state = S_ADD_SCAN;
                        end
                        KIND_ADD_AT: begin
                            n_res_slot = i_slot;
                            if (32'(i_slot) < 32'(SLOTS)) begin
                                n_state = S_AT_CHK;
                            end else begin
                                n_res_status = STAT_FULL;
                                n_state      = S_DONE;
                            end
                        end
                        KIND_REMOVE: begin
                            n_res_slot = i_slot;
                            if (32'(i_slot) < 32'(SLOTS)) begin
                                n_state = S_RM_CHK;
                            end else begin
                                n_res_status = STAT_EMPTY;
                                n_state      = S_DONE;
                            end
                        end
                        KIND_READ: begin
                            if (32'(i_position) >= 32'(r_count)) begin
                                n_res_status = STAT_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_RD_SLOT;
                            end
                        end
                        KIND_CLEAR: begin
                            n_emit  = 1'b1;
                            n_top   = '0;
                            n_count = '0;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                s_we    = 1'b1;
                s_waddr = r_idx;
                s_wdata = '0;
                if (r_idx == AW'(SLOTS - 1)) begin
                    n_state = r_emit ? S_DONE : S_IDLE;
                    n_emit  = 1'b0;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_ADD_SCAN: begin
                s_raddr = r_idx;
                n_idx   = (r_idx == r_top) ? r_idx : r_idx + AW'(1);
                if (r_pvalid) begin
                    if (!occ) begin
                        claim_en   = 1'b1;
                        claim_slot = r_pidx;
                        n_res_slot = SLOT_W'(r_pidx);
                        n_state    = S_DONE;
                    end else if (r_pidx == r_top) begin
                        if (r_top == AW'(SLOTS - 1)) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            claim_en   = 1'b1;
                            claim_slot = r_top + AW'(1);
                            n_top      = r_top + AW'(1);
                            n_res_slot = SLOT_W'(r_top + AW'(1));
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_AT_CHK: begin
                if (occ) begin
                    n_res_status = STAT_OCCUPIED;
                end else begin
                    claim_en   = 1'b1;
                    claim_slot = AW'(r_slot);
                    if (AW'(r_slot) > r_top) begin
                        n_top = AW'(r_slot);
                    end
                end
                n_state = S_DONE;
            end
            S_RM_CHK: begin
                if (!occ) begin
                    n_res_status = STAT_EMPTY;
                    n_state      = S_DONE;
                end else begin
                    s_we     = 1'b1;
                    s_waddr  = AW'(r_slot);
                    s_wdata  = {1'b0, r_sdata[HANDLE_W-1:0]};
                    n_idx    = r_top;
                    n_pvalid = 1'b0;
                    n_state  = S_SHRINK;
                end
            end
            S_SHRINK: begin
                s_raddr = r_idx;
                n_idx   = (r_idx == '0) ? r_idx : r_idx - AW'(1);
                if (r_pvalid && (occ || r_pidx == '0)) begin
                    n_top    = r_pidx;
                    n_idx    = '0;
                    n_pvalid = 1'b0;
                    n_state  = S_DSCAN;
                end
            end
            S_DSCAN: begin
                d_raddr = r_idx;
                n_idx   = (r_idx == last_pos) ? r_idx : r_idx + AW'(1);
                if (r_pvalid && r_ddata == AW'(r_slot)) begin
                    n_idx   = r_pidx;
                    n_state = S_DMOVE_RD;
                end
            end
            S_DMOVE_RD: begin
                d_raddr = last_pos;
                n_count = r_count - CW'(1);
                n_state = S_DMOVE_WR;
            end
            S_DMOVE_WR: begin
                d_we    = 1'b1;
                d_waddr = r_idx;
                d_wdata = r_ddata;
                n_state = S_DONE;
            end
            S_RD_SLOT: begin
                s_raddr    = r_ddata;
                n_res_slot = SLOT_W'(r_ddata);
                n_state    = S_RD_HANDLE;
            end
            S_RD_HANDLE: begin
                n_res_handle = r_sdata[HANDLE_W-1:0];
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_handle = r_res_handle;
                    n_out_live   = LIVE_W'(r_count);
                    n_out_top    = SLOT_W'(r_top);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (claim_en) begin
            s_we    = 1'b1;
            s_waddr = claim_slot;
            s_wdata = {1'b1, r_handle};
            if (r_count < CW'(SLOTS)) begin
                d_we    = 1'b1;
                d_waddr = AW'(r_count);
                d_wdata = claim_slot;
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_idx       <= '0;
            r_pvalid    <= 1'b0;
            r_top       <= '0;
            r_count     <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pvalid    <= n_pvalid;
            r_top       <= n_top;
            r_count     <= n_count;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx       <= r_idx;
        r_slot       <= n_slot;
        r_handle     <= n_handle;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_handle <= n_res_handle;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_handle <= n_out_handle;
        r_out_live   <= n_out_live;
        r_out_top    <= n_out_top;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_slot_mem[s_waddr] <= s_wdata;
        end
        r_sdata <= r_slot_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dense_mem[d_waddr] <= d_wdata;
        end
        r_ddata <= r_dense_mem[d_raddr];
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_out   = r_out_slot;
    assign o_handle_out = r_out_handle;
    assign o_live_count = r_out_live;
    assign o_top_slot   = r_out_top;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("live count exceeds the table size");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result word raised outside the done state");

    a_shrink_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHRINK) |=> (r_top <= $past(r_top)))
        else $error("highest index grew while shrinking");

    a_dscan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSCAN) |-> (r_count != '0))
        else $error("dense list search with an empty list");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sltd_pkg::*;

    localparam int TB_SLOTS      = DEFAULT_SLOTS;
    localparam int RANDOM_WORDS  = 1000;
    localparam int SETTLE_CYCLES = 2 * TB_SLOTS + 16;

    localparam t_kind KIND_SPARE_LO = 3'd5;
    localparam t_kind KIND_SPARE_HI = 3'd7;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_READS} t_phase;

    typedef struct {
        t_status               status;
        logic [SLOT_W-1:0]     slot;
        logic [HANDLE_W-1:0]   handle;
        logic [LIVE_W-1:0]     live;
        logic [SLOT_W-1:0]     top;
    } t_slot_result;

    class slot_table_tracker;
        bit                  occupied [TB_SLOTS];
        bit [HANDLE_W-1:0]   handles [TB_SLOTS];
        bit [SLOT_W-1:0]     dense [TB_SLOTS];
        bit [SLOT_W-1:0]     top;
        bit [LIVE_W-1:0]     live;
        t_slot_result        pending_results[$];
        int                  mismatches;

        function new();
            foreach (occupied[i]) occupied[i] = 1'b0;
            top = '0;
            live = '0;
            mismatches = 0;
        endfunction

        function void claim(int s, bit [HANDLE_W-1:0] h);
            occupied[s] = 1'b1;
            handles[s] = h;
            if (live < TB_SLOTS) begin
                dense[live] = SLOT_W'(s);
                live++;
            end
        endfunction

        function void note_request(t_kind kind, bit [SLOT_W-1:0] slot, bit [POS_W-1:0] pos,
                                   bit [HANDLE_W-1:0] handle);
            t_slot_result r;
            bit found;
            r.status = STAT_OK;
            r.slot = '0;
            r.handle = '0;
            found = 1'b0;
            case (kind)
                KIND_ADD: begin
                    for (int i = 0; i <= top && !found; i++) begin
                        if (!occupied[i]) begin
                            claim(i, handle);
                            r.slot = SLOT_W'(i);
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        if (top == TB_SLOTS - 1) begin
                            r.status = STAT_FULL;
                        end else begin
                            top = top + SLOT_W'(1);
                            claim(top, handle);
                            r.slot = top;
                        end
                    end
                end
                KIND_ADD_AT: begin
                    r.slot = slot;
                    if (slot >= TB_SLOTS) begin
                        r.status = STAT_FULL;
                    end else if (occupied[slot]) begin
                        r.status = STAT_OCCUPIED;
                    end else begin
                        if (slot > top) top = slot;
                        claim(slot, handle);
                    end
                end
                KIND_REMOVE: begin
                    r.slot = slot;
                    if (slot >= TB_SLOTS || !occupied[slot]) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        occupied[slot] = 1'b0;
                        while (top > 0 && !occupied[top]) top--;
                        for (int i = 0; i < live && !found; i++) begin
                            if (dense[i] == slot) begin
                                live--;
                                dense[i] = dense[live];
                                found = 1'b1;
                            end
                        end
                    end
                end
                KIND_READ: begin
                    if (pos >= live) begin
                        r.status = STAT_RANGE;
                    end else begin
                        r.slot = dense[pos];
                        r.handle = handles[dense[pos]];
                    end
                end
                KIND_CLEAR: begin
                    foreach (occupied[i]) occupied[i] = 1'b0;
                    top = '0;
                    live = '0;
                end
                default: begin
                end
            endcase
            r.live = live;
            r.top = top;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] expected, logic [15:0] actual);
            if (actual !== expected) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                         actual);
                mismatches++;
            end
        endfunction

        function void check_result(t_status status, logic [SLOT_W-1:0] slot,
                                   logic [HANDLE_W-1:0] handle, logic [LIVE_W-1:0] live_out,
                                   logic [SLOT_W-1:0] top_out);
            t_slot_result exp;
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected, expected none, actual status %0d",
                         $time, status);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            compare_field("status", 16'(exp.status), 16'(status));
            compare_field("slot_out", 16'(exp.slot), 16'(slot));
            compare_field("handle_out", exp.handle, handle);
            compare_field("live_count", 16'(exp.live), 16'(live_out));
            compare_field("top_slot", 16'(exp.top), 16'(top_out));
        endfunction

        function int random_slot_with(bit want_occupied);
            int choices[$];
            for (int i = 0; i < TB_SLOTS; i++) begin
                if (occupied[i] == want_occupied) choices.push_back(i);
            end
            if (choices.size() == 0) return $urandom_range(0, TB_SLOTS - 1);
            return choices[$urandom_range(0, choices.size() - 1)];
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [KIND_W-1:0]   i_kind;
    logic [SLOT_W-1:0]   i_slot;
    logic [POS_W-1:0]    i_position;
    logic [HANDLE_W-1:0] i_handle;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_out;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [LIVE_W-1:0]   o_live_count;
    logic [SLOT_W-1:0]   o_top_slot;

    slot_table_tracker tracker = new();
    int words_sent = 0;
    int burst_left = 0;

    slot_table_with_dense_list #(
        .SLOTS(TB_SLOTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_slot       (i_slot),
        .i_position   (i_position),
        .i_handle     (i_handle),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out),
        .o_handle_out (o_handle_out),
        .o_live_count (o_live_count),
        .o_top_slot   (o_top_slot)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [HANDLE_W-1:0] random_handle();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return HANDLE_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic send_word(t_kind kind, logic [SLOT_W-1:0] slot, logic [POS_W-1:0] pos,
                             logic [HANDLE_W-1:0] handle);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_slot <= slot;
        i_position <= pos;
        i_handle <= handle;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_request(kind, slot, pos, handle);
        if (kind < KIND_SPARE_LO) words_sent++;
        pace_sender();
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_word(t_phase phase);
        int roll;
        t_kind kind;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0] pos;
        roll = $urandom_range(0, 99);
        slot = SLOT_W'($urandom_range(0, TB_SLOTS - 1));
        pos = POS_W'($urandom_range(0, 63));
        case (phase)
            PH_GROW: kind = roll < 50 ? KIND_ADD : roll < 75 ? KIND_ADD_AT :
                            roll < 85 ? KIND_REMOVE : KIND_READ;
            PH_SHRINK: kind = roll < 15 ? KIND_ADD : roll < 20 ? KIND_ADD_AT :
                              roll < 80 ? KIND_REMOVE : KIND_READ;
            PH_READS: kind = roll < 10 ? KIND_ADD : roll < 15 ? KIND_ADD_AT :
                             roll < 25 ? KIND_REMOVE : KIND_READ;
            default: kind = roll < 25 ? KIND_ADD : roll < 45 ? KIND_ADD_AT :
                            roll < 70 ? KIND_REMOVE : roll < 97 ? KIND_READ :
                            roll < 98 ? KIND_CLEAR :
                            t_kind'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        endcase
        if (kind == KIND_ADD_AT && $urandom_range(0, 3) != 0) begin
            slot = SLOT_W'(tracker.random_slot_with(1'b0));
        end
        if (kind == KIND_REMOVE && $urandom_range(0, 4) != 0) begin
            slot = SLOT_W'(tracker.random_slot_with(1'b1));
        end
        if (kind == KIND_READ && tracker.live != 0 && $urandom_range(0, 6) != 0) begin
            pos = POS_W'($urandom_range(0, tracker.live - 1));
        end
        send_word(kind, slot, pos, random_handle());
    endtask

    initial begin : result_sink
        int hold;
        int ready_mode;
        hold = 0;
        ready_mode = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                tracker.check_result(o_status, o_slot_out, o_handle_out, o_live_count,
                                     o_top_slot);
            end
            if (hold == 0) begin
                ready_mode = $urandom_range(0, 3);
                hold = $urandom_range(8, 80);
            end
            hold--;
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 1);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (hold < 4);
            endcase
        end
    end

    initial begin : stimulus
        int phase_len;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind <= KIND_ADD;
        i_slot <= '0;
        i_position <= '0;
        i_handle <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(KIND_READ, 6'd0, 6'd0, 16'h0000);
        send_word(KIND_REMOVE, 6'd5, 6'd0, 16'h0000);
        send_word(KIND_ADD, 6'd0, 6'd0, 16'hFFFF);
        send_word(KIND_ADD, 6'd63, 6'd63, 16'h0000);
        send_word(KIND_ADD_AT, 6'd63, 6'd0, 16'hA5A5);
        send_word(KIND_ADD_AT, 6'd63, 6'd0, 16'h5A5A);
        send_word(KIND_ADD, 6'd0, 6'd0, 16'h1234);
        send_word(KIND_READ, 6'd0, 6'd2, 16'h0000);
        send_word(KIND_READ, 6'd0, 6'd63, 16'h0000);
        send_word(KIND_REMOVE, 6'd1, 6'd0, 16'h0000);
        send_word(KIND_READ, 6'd0, 6'd1, 16'h0000);
        send_word(KIND_REMOVE, 6'd63, 6'd0, 16'h0000);
        send_word(KIND_SPARE_LO, 6'd63, 6'd63, 16'hFFFF);
        send_word(KIND_SPARE_LO + 3'd1, 6'd0, 6'd0, 16'h0000);
        send_word(KIND_SPARE_HI, 6'd21, 6'd42, 16'h5555);
        send_word(KIND_ADD, 6'd0, 6'd0, 16'hBEEF);
        send_word(KIND_CLEAR, 6'd0, 6'd0, 16'h0000);
        send_word(KIND_READ, 6'd0, 6'd0, 16'h0000);
        send_word(KIND_ADD_AT, 6'd0, 6'd0, 16'h5A5A);
        send_word(KIND_REMOVE, 6'd0, 6'd0, 16'h0000);
        send_word(KIND_REMOVE, 6'd0, 6'd0, 16'h0000);
        drain_results();

        while (tracker.live != TB_SLOTS) begin
            if ($urandom_range(0, 2) == 0) begin
                send_word(KIND_ADD_AT, SLOT_W'(tracker.random_slot_with(1'b0)),
                          POS_W'($urandom_range(0, 63)), random_handle());
            end else begin
                send_word(KIND_ADD, SLOT_W'($urandom_range(0, 63)),
                          POS_W'($urandom_range(0, 63)), random_handle());
            end
        end
        send_word(KIND_ADD, SLOT_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                  random_handle());
        send_word(KIND_ADD, SLOT_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                  random_handle());
        send_word(KIND_ADD_AT, SLOT_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                  random_handle());
        send_word(KIND_READ, SLOT_W'($urandom_range(0, 63)), 6'd63, random_handle());
        repeat (150) send_random_word(PH_SHRINK);

        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 2) == 0) drain_results();
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) send_random_word(t_phase'($urandom_range(0, 3)));
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("** slot_table_with_dense_list: PASSED **");
        end else begin
            $display("** slot_table_with_dense_list: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("%0t: run did not finish in time", $time);
        $display("** slot_table_with_dense_list: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/sltd_pkg.sv
rtl/core/slot_table_with_dense_list.sv
dv/testbench.sv
